/* rtl/core/iacu_pkg.sv */
// iacu_pkg: shared types, codes and constants of the idempotent actuator command unit
// no dependencies; compiled first

package iacu_pkg;

	localparam int CACHE_ENTRIES_DEF = 8;
	localparam int KEY_BITS_DEF      = 64;

	localparam int KEY_W    = 64;
	localparam int TPS_W    = 10;
	localparam int MAX_W    = 12;
	localparam int DUR_W    = 12;
	localparam int TICK_W   = 32;
	localparam int PROD_W   = TPS_W + DUR_W;
	localparam int CFG_W    = 12;
	localparam int CFG_IDX_W = 1;
	localparam int STATUS_W = 3;

	localparam logic [1:0] ACT_CMD  = 2'd0;
	localparam logic [1:0] ACT_TICK = 2'd1;
	localparam logic [1:0] ACT_POLL = 2'd2;

	localparam logic [1:0] SEL_FAN   = 2'd0;
	localparam logic [1:0] SEL_LIGHT = 2'd1;

	localparam logic [1:0] RQ_OFF = 2'd0;
	localparam logic [1:0] RQ_ON  = 2'd1;

	localparam logic [STATUS_W-1:0] STS_APPLIED   = 3'd0;
	localparam logic [STATUS_W-1:0] STS_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] STS_INVALID   = 3'd2;
	localparam logic [STATUS_W-1:0] STS_MISMATCH  = 3'd3;
	localparam logic [STATUS_W-1:0] STS_POLL      = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_TPS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX = 1'b1;

	localparam logic [TPS_W-1:0] TPS_RST = 10'd100;
	localparam logic [MAX_W-1:0] MAX_RST = 12'd3600;

	typedef struct packed {
		logic [1:0]       action;
		logic [KEY_W-1:0] command_key;
		logic             well_formed;
		logic [1:0]       actuator_sel;
		logic [1:0]       requested_state;
		logic [DUR_W-1:0] duration;
	} cmd_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                fan_is_on;
		logic                light_is_on;
		logic                fan_timed_out;
		logic                light_timed_out;
	} res_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_POLL_FAN,
		ST_POLL_LIGHT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic commit;
		logic act;
		logic st;
	} cache_req_t;

	typedef struct packed {
		logic done;
		logic hit;
		logic same;
	} cache_rsp_t;

endpackage

/* rtl/core/iacu_if.sv */
// iacu_cmd_if, iacu_res_if: valid/ready channels for command requests and results
// depends on iacu_pkg

interface iacu_cmd_if;
	logic                 valid;
	logic                 ready;
	iacu_pkg::cmd_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface iacu_res_if;
	logic                 valid;
	logic                 ready;
	iacu_pkg::res_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/iacu_cache.sv */
// iacu_cache: ring cache of applied command keys with a one-entry-per-cycle scan
// depends on iacu_pkg

module iacu_cache #(
	parameter int CACHE_ENTRIES = iacu_pkg::CACHE_ENTRIES_DEF,
	parameter int KEY_BITS      = iacu_pkg::KEY_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iacu_pkg::cache_req_t req,
	input  logic [KEY_BITS-1:0]  key,
	output iacu_pkg::cache_rsp_t rsp
);

	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int ENT_W = KEY_BITS + 2;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(CACHE_ENTRIES - 1);

	logic [ENT_W-1:0]         mem_q [CACHE_ENTRIES];
	logic [ENT_W-1:0]         rd_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     cmp_s1;
	logic [CACHE_ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]         cursor_q;
	logic [IDX_W-1:0]         scan_q;
	logic                     scanning_q;
	logic                     hit;

	assign hit      = cmp_s1 && valid_q[idx_s1] && (rd_s1[ENT_W-1:2] == key);
	assign rsp.hit  = hit;
	assign rsp.done = cmp_s1 && (hit || idx_s1 == LAST);
	assign rsp.same = (rd_s1[1] == req.act) && (rd_s1[0] == req.st);

	always_ff @(posedge clk) begin
		if (req.commit) begin
			mem_q[cursor_q] <= {key, req.act, req.st};
		end
		rd_s1  <= mem_q[scan_q];
		idx_s1 <= scan_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			cursor_q   <= '0;
			scan_q     <= '0;
			scanning_q <= 1'b0;
			cmp_s1     <= 1'b0;
		end else begin
			if (req.start) begin
				scanning_q <= 1'b1;
				scan_q     <= '0;
				cmp_s1     <= 1'b0;
			end else begin
				cmp_s1 <= scanning_q && !hit;
				if (scanning_q) begin
					if (hit || scan_q == LAST) begin
						scanning_q <= 1'b0;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
			end
			if (req.commit) begin
				valid_q[cursor_q] <= 1'b1;
				cursor_q <= (cursor_q == LAST) ? '0 : cursor_q + 1'b1;
			end
		end
	end

endmodule

/* rtl/core/idempotent_actuator_command_unit.sv */
// idempotent_actuator_command_unit: top level, command sequencer and actuator state
// depends on iacu_pkg, iacu_if, iacu_cache

// Takes command, tick and poll requests for a fan and a grow light and answers
// every command and poll with one result. A tick gives no result. An invalid
// command goes straight to the result stage. A valid command reads the key
// cache through its read port one entry per cycle until the key is found or
// the ring is exhausted; on a miss the command is then applied through the
// shared 32-bit adder. Every result is loaded into the result register. A poll
// makes one adder pass per actuator deadline. A result may wait in the output
// register while the next request is taken. Configuration writes must arrive
// while the unit is idle.
module idempotent_actuator_command_unit #(
	parameter int CACHE_ENTRIES = iacu_pkg::CACHE_ENTRIES_DEF,
	parameter int KEY_BITS      = iacu_pkg::KEY_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	iacu_cmd_if.sink                           cmd,
	iacu_res_if.source                         res,
	input  logic                               cfg_we,
	input  logic [iacu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [iacu_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int TW = iacu_pkg::TICK_W;

	iacu_pkg::state_t     state_q, state_d;
	iacu_pkg::cache_req_t creq;
	iacu_pkg::cache_rsp_t crsp;
	iacu_pkg::cmd_item_t  item;
	iacu_pkg::res_item_t  res_q;

	logic [iacu_pkg::TPS_W-1:0]  tps_q;
	logic [iacu_pkg::MAX_W-1:0]  max_q;
	logic [TW-1:0]               tick_q;
	logic                        fan_on_q, light_on_q;
	logic [TW-1:0]               fan_dl_q, light_dl_q;
	logic [KEY_BITS-1:0]         key_q;
	logic                        act_q, st_q, dur_nz_q;
	logic [iacu_pkg::PROD_W-1:0] prod_q;
	logic [iacu_pkg::STATUS_W-1:0] status_q;
	logic                        fto_q, lto_q;
	logic                        out_valid_q;

	logic          accept, bad, out_free, sub;
	logic [TW-1:0] op_b, sum, new_dl;
	logic          passed;

	assign item      = cmd.data;
	assign cmd.ready = (state_q == iacu_pkg::ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || res.ready;
	assign res.valid = out_valid_q;
	assign res.data  = res_q;

	assign bad = !item.well_formed
		|| (item.actuator_sel > iacu_pkg::SEL_LIGHT)
		|| (item.requested_state > iacu_pkg::RQ_ON)
		|| (item.duration > max_q)
		|| (item.requested_state == iacu_pkg::RQ_ON && item.actuator_sel == iacu_pkg::SEL_FAN
			&& item.duration == '0)
		|| (item.requested_state == iacu_pkg::RQ_OFF && item.duration != '0);

	// shared adder: deadline arming adds, deadline checks subtract
	always_comb begin
		sub  = (state_q == iacu_pkg::ST_POLL_FAN) || (state_q == iacu_pkg::ST_POLL_LIGHT);
		op_b = TW'(prod_q);
		if (state_q == iacu_pkg::ST_POLL_FAN) begin
			op_b = fan_dl_q;
		end else if (state_q == iacu_pkg::ST_POLL_LIGHT) begin
			op_b = light_dl_q;
		end
		sum    = tick_q + (op_b ^ {TW{sub}}) + TW'(sub);
		passed = (op_b != '0) && !sum[TW-1];
		new_dl = (st_q && dur_nz_q) ? sum : '0;
	end

	always_comb begin
		state_d     = state_q;
		creq.start  = 1'b0;
		creq.commit = 1'b0;
		creq.act    = act_q;
		creq.st     = st_q;
		case (state_q)
			iacu_pkg::ST_IDLE: begin
				if (accept) begin
					case (item.action)
						iacu_pkg::ACT_CMD: begin
							if (bad) begin
								state_d = iacu_pkg::ST_EMIT;
							end else begin
								creq.start = 1'b1;
								state_d    = iacu_pkg::ST_SCAN;
							end
						end
						iacu_pkg::ACT_POLL: state_d = iacu_pkg::ST_POLL_FAN;
						default: ;
					endcase
				end
			end
			iacu_pkg::ST_SCAN: begin
				if (crsp.done) begin
					state_d = crsp.hit ? iacu_pkg::ST_EMIT : iacu_pkg::ST_APPLY;
				end
			end
			iacu_pkg::ST_APPLY: begin
				creq.commit = 1'b1;
				state_d     = iacu_pkg::ST_EMIT;
			end
			iacu_pkg::ST_POLL_FAN:   state_d = iacu_pkg::ST_POLL_LIGHT;
			iacu_pkg::ST_POLL_LIGHT: state_d = iacu_pkg::ST_EMIT;
			iacu_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = iacu_pkg::ST_IDLE;
				end
			end
			default: state_d = iacu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iacu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= iacu_pkg::TPS_RST;
			max_q <= iacu_pkg::MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				iacu_pkg::CFG_TPS: tps_q <= cfg_wdata[iacu_pkg::TPS_W-1:0];
				iacu_pkg::CFG_MAX: max_q <= cfg_wdata[iacu_pkg::MAX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			fan_on_q    <= 1'b0;
			light_on_q  <= 1'b0;
			fan_dl_q    <= '0;
			light_dl_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && item.action == iacu_pkg::ACT_TICK) begin
				tick_q <= tick_q + 1'b1;
			end
			if (state_q == iacu_pkg::ST_APPLY) begin
				if (!act_q) begin
					fan_on_q <= st_q;
					fan_dl_q <= new_dl;
				end else begin
					light_on_q <= st_q;
					light_dl_q <= new_dl;
				end
			end
			if (state_q == iacu_pkg::ST_POLL_FAN && fan_on_q && passed) begin
				fan_on_q <= 1'b0;
				fan_dl_q <= '0;
			end
			if (state_q == iacu_pkg::ST_POLL_LIGHT && light_on_q && passed) begin
				light_on_q <= 1'b0;
				light_dl_q <= '0;
			end
			if (state_q == iacu_pkg::ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= item.command_key[KEY_BITS-1:0];
			act_q    <= item.actuator_sel[0];
			st_q     <= item.requested_state[0];
			dur_nz_q <= (item.duration != '0);
			prod_q   <= iacu_pkg::PROD_W'(item.duration) * iacu_pkg::PROD_W'(tps_q);
			fto_q    <= 1'b0;
			lto_q    <= 1'b0;
			status_q <= (item.action == iacu_pkg::ACT_POLL) ? iacu_pkg::STS_POLL
				: iacu_pkg::STS_INVALID;
		end
		if (state_q == iacu_pkg::ST_SCAN && crsp.done && crsp.hit) begin
			status_q <= crsp.same ? iacu_pkg::STS_DUPLICATE : iacu_pkg::STS_MISMATCH;
		end
		if (state_q == iacu_pkg::ST_APPLY) begin
			status_q <= iacu_pkg::STS_APPLIED;
		end
		if (state_q == iacu_pkg::ST_POLL_FAN && fan_on_q && passed) begin
			fto_q <= 1'b1;
		end
		if (state_q == iacu_pkg::ST_POLL_LIGHT && light_on_q && passed) begin
			lto_q <= 1'b1;
		end
		if (state_q == iacu_pkg::ST_EMIT && out_free) begin
			res_q.status          <= status_q;
			res_q.fan_is_on       <= fan_on_q;
			res_q.light_is_on     <= light_on_q;
			res_q.fan_timed_out   <= fto_q;
			res_q.light_timed_out <= lto_q;
		end
	end

	iacu_cache #(
		.CACHE_ENTRIES(CACHE_ENTRIES),
		.KEY_BITS     (KEY_BITS)
	) u_cache (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (creq),
		.key   (key_q),
		.rsp   (crsp)
	);

	// a poll never switches an actuator on
	a_poll_no_turn_on: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == iacu_pkg::ST_POLL_FAN || state_q == iacu_pkg::ST_POLL_LIGHT)
		|=> !(fan_on_q && !$past(fan_on_q)) && !(light_on_q && !$past(light_on_q)))
		else $error("poll switched an actuator on");

	// timeout flags only on poll results, and a timed-out actuator reads as off
	a_timeout_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.data.fan_timed_out || res.data.light_timed_out)
		|-> res.data.status == iacu_pkg::STS_POLL
		&& !(res.data.fan_timed_out && res.data.fan_is_on)
		&& !(res.data.light_timed_out && res.data.light_is_on))
		else $error("timeout flags inconsistent with result");

	// the cache is written only after a scan that found no match
	a_commit_after_miss: assert property (@(posedge clk) disable iff (!arst_n)
		creq.commit |-> $past(state_q) == iacu_pkg::ST_SCAN && $past(crsp.done)
		&& !$past(crsp.hit))
		else $error("cache write without a completed miss");

endmodule

/* bench/tb_idempotent_actuator_command_unit.sv */
// tb_idempotent_actuator_command_unit: self-checking bench for the actuator command unit
// drives command, tick and poll requests with random gaps and back pressure and checks
// every result against a cycle-free model kept in the bench; depends on iacu_pkg and iacu_if

module tb_idempotent_actuator_command_unit;
	import iacu_pkg::*;

	localparam int CACHE_DEPTH    = CACHE_ENTRIES_DEF;
	localparam int POOL_SIZE      = 12;
	localparam int SETTLE_CYCLES  = 24;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 310;

	localparam logic [1:0] ACT_UNUSED  = 2'd3;
	localparam logic [1:0] SEL_UNKNOWN = 2'd2;
	localparam logic [1:0] SEL_SPARE   = 2'd3;
	localparam logic [1:0] RQ_OTHER    = 2'd2;
	localparam logic [1:0] RQ_SPARE    = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	iacu_cmd_if cmd_ch ();
	iacu_res_if res_ch ();

	idempotent_actuator_command_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// model of the unit
	logic [TPS_W-1:0]  model_tps = TPS_RST;
	logic [MAX_W-1:0]  model_max_run = MAX_RST;
	logic [TICK_W-1:0] model_tick = '0;
	logic              model_fan_on = 1'b0;
	logic              model_light_on = 1'b0;
	logic [TICK_W-1:0] model_fan_dl = '0;
	logic [TICK_W-1:0] model_light_dl = '0;
	logic [KEY_W-1:0]  seen_key [CACHE_DEPTH];
	logic              seen_act [CACHE_DEPTH];
	logic              seen_st [CACHE_DEPTH];
	bit                seen_vld [CACHE_DEPTH];
	int                ring_pos = 0;

	res_item_t pending_outcomes [$];
	int error_count = 0;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	bit quick_source = 1'b0;
	logic quick_sink = 1'b0;
	logic hold_results = 1'b0;
	int quiet_cycles = 0;

	function automatic bit deadline_due(logic [TICK_W-1:0] dl);
		logic [TICK_W-1:0] lag;
		lag = model_tick - dl;
		return (dl != '0) && !lag[TICK_W-1];
	endfunction

	function automatic bit command_ok(cmd_item_t it);
		bit sel_ok;
		bit state_ok;
		sel_ok = (it.actuator_sel == SEL_FAN) || (it.actuator_sel == SEL_LIGHT);
		state_ok = (it.requested_state == RQ_OFF) || (it.requested_state == RQ_ON);
		if (!it.well_formed || !sel_ok || !state_ok || it.duration > model_max_run)
			return 1'b0;
		if (it.requested_state == RQ_ON && it.actuator_sel == SEL_FAN && it.duration == '0)
			return 1'b0;
		if (it.requested_state == RQ_OFF && it.duration != '0)
			return 1'b0;
		return 1'b1;
	endfunction

	task automatic predict_outcome(input cmd_item_t it);
		res_item_t r;
		logic [TICK_W-1:0] dl;
		bit hit;
		r = '0;
		if (it.action == ACT_TICK) begin
			model_tick = model_tick + 32'd1;
		end else if (it.action == ACT_POLL) begin
			if (model_fan_on && deadline_due(model_fan_dl)) begin
				model_fan_on = 1'b0;
				model_fan_dl = '0;
				r.fan_timed_out = 1'b1;
			end
			if (model_light_on && deadline_due(model_light_dl)) begin
				model_light_on = 1'b0;
				model_light_dl = '0;
				r.light_timed_out = 1'b1;
			end
			r.status = STS_POLL;
			r.fan_is_on = model_fan_on;
			r.light_is_on = model_light_on;
			pending_outcomes.push_back(r);
		end else if (it.action == ACT_CMD) begin
			if (!command_ok(it)) begin
				r.status = STS_INVALID;
			end else begin
				hit = 1'b0;
				for (int i = 0; i < CACHE_DEPTH; i++) begin
					if (!hit && seen_vld[i] && seen_key[i] == it.command_key) begin
						hit = 1'b1;
						if (seen_act[i] == it.actuator_sel[0] && seen_st[i] == it.requested_state[0])
							r.status = STS_DUPLICATE;
						else
							r.status = STS_MISMATCH;
					end
				end
				if (!hit) begin
					dl = '0;
					if (it.requested_state == RQ_ON && it.duration != '0)
						dl = model_tick + (32'(it.duration) * 32'(model_tps));
					if (it.actuator_sel == SEL_FAN) begin
						model_fan_on = (it.requested_state == RQ_ON);
						model_fan_dl = dl;
					end else begin
						model_light_on = (it.requested_state == RQ_ON);
						model_light_dl = dl;
					end
					seen_key[ring_pos] = it.command_key;
					seen_act[ring_pos] = it.actuator_sel[0];
					seen_st[ring_pos] = it.requested_state[0];
					seen_vld[ring_pos] = 1'b1;
					ring_pos = (ring_pos + 1) % CACHE_DEPTH;
					r.status = STS_APPLIED;
				end
			end
			r.fan_is_on = model_fan_on;
			r.light_is_on = model_light_on;
			pending_outcomes.push_back(r);
		end
	endtask

	task automatic check_result(input res_item_t got);
		res_item_t want;
		if (pending_outcomes.size() == 0) begin
			$error("result with no request waiting: status %0d", got.status);
			error_count++;
		end else begin
			want = pending_outcomes.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				error_count++;
			end
			if (got.fan_is_on !== want.fan_is_on) begin
				$error("fan_is_on: expected %0d, actual %0d", want.fan_is_on, got.fan_is_on);
				error_count++;
			end
			if (got.light_is_on !== want.light_is_on) begin
				$error("light_is_on: expected %0d, actual %0d", want.light_is_on,
					got.light_is_on);
				error_count++;
			end
			if (got.fan_timed_out !== want.fan_timed_out) begin
				$error("fan_timed_out: expected %0d, actual %0d", want.fan_timed_out,
					got.fan_timed_out);
				error_count++;
			end
			if (got.light_timed_out !== want.light_timed_out) begin
				$error("light_timed_out: expected %0d, actual %0d", want.light_timed_out,
					got.light_timed_out);
				error_count++;
			end
		end
	endtask

	function automatic cmd_item_t make_command(logic [KEY_W-1:0] key, logic wf,
		logic [1:0] sel, logic [1:0] state, logic [DUR_W-1:0] dur);
		cmd_item_t it;
		it.action = ACT_CMD;
		it.command_key = key;
		it.well_formed = wf;
		it.actuator_sel = sel;
		it.requested_state = state;
		it.duration = dur;
		return it;
	endfunction

	function automatic cmd_item_t make_action(logic [1:0] act);
		cmd_item_t it;
		it = '0;
		it.action = act;
		return it;
	endfunction

	// ticks, polls and commands, the commands mostly well-formed and often on a small key pool, the rest noise
	function automatic cmd_item_t random_request(bit want_result);
		cmd_item_t it;
		int pick;
		int lim;
		it.action = 2'($urandom);
		it.command_key = {$urandom, $urandom};
		it.well_formed = 1'($urandom);
		it.actuator_sel = 2'($urandom);
		it.requested_state = 2'($urandom);
		it.duration = 12'($urandom);
		pick = want_result ? $urandom_range(42, 99) : $urandom_range(0, 99);
		if (pick < 40) begin
			it.action = ACT_TICK;
		end else if (pick < 42) begin
			it.action = ACT_UNUSED;
		end else if (pick < 54) begin
			it.action = ACT_POLL;
		end else begin
			it.action = ACT_CMD;
			if ($urandom_range(0, 99) < 65)
				it.command_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			if ($urandom_range(0, 99) < 80) begin
				it.well_formed = 1'b1;
				it.actuator_sel = $urandom_range(0, 1) ? SEL_LIGHT : SEL_FAN;
				it.requested_state = $urandom_range(0, 1) ? RQ_ON : RQ_OFF;
				lim = (model_max_run < 8) ? int'(model_max_run) : 8;
				if (it.requested_state == RQ_OFF)
					it.duration = '0;
				else if (lim == 0 || (it.actuator_sel == SEL_LIGHT && $urandom_range(0, 5) == 0))
					it.duration = '0;
				else if ($urandom_range(0, 6) == 0)
					it.duration = 12'($urandom_range(1, model_max_run));
				else
					it.duration = 12'($urandom_range(1, lim));
				if (model_max_run < 12'hFFF && $urandom_range(0, 19) == 0)
					it.duration = model_max_run + 12'd1;
			end
		end
		return it;
	endfunction

	task automatic issue_request(input cmd_item_t item);
		int gap;
		gap = quick_source ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= item;
		do @(posedge clk); while (!cmd_ch.ready);
		predict_outcome(item);
	endtask

	task automatic release_requests();
		cmd_ch.valid <= 1'b0;
	endtask

	task automatic wait_until_idle();
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TPS)
			model_tps = value[TPS_W-1:0];
		else
			model_max_run = value[MAX_W-1:0];
		@(posedge clk);
	endtask

	task automatic test_reset_values_and_validation();
		issue_request(make_action(ACT_POLL));
		issue_request(make_command(64'd0, 1'b1, SEL_FAN, RQ_ON, 12'd3600));
		issue_request(make_command(64'd1, 1'b1, SEL_LIGHT, RQ_ON, 12'd3601));
		issue_request(make_command('1, 1'b0, SEL_LIGHT, RQ_ON, 12'd1));
		issue_request(make_command(64'd5, 1'b1, SEL_UNKNOWN, RQ_ON, 12'd1));
		issue_request(make_command(64'd5, 1'b1, SEL_SPARE, RQ_OFF, 12'd0));
		issue_request(make_command(64'd6, 1'b1, SEL_LIGHT, RQ_OTHER, 12'd0));
		issue_request(make_command(64'd6, 1'b1, SEL_FAN, RQ_SPARE, 12'd0));
		issue_request(make_command(64'd7, 1'b1, SEL_FAN, RQ_ON, 12'd0));
		issue_request(make_command(64'd7, 1'b1, SEL_LIGHT, RQ_OFF, 12'd5));
		// light on with no duration runs without a deadline
		issue_request(make_command('1, 1'b1, SEL_LIGHT, RQ_ON, 12'd0));
		issue_request(make_command(64'd0, 1'b1, SEL_FAN, RQ_ON, 12'd3600));
		issue_request(make_command(64'd0, 1'b1, SEL_FAN, RQ_OFF, 12'd0));
		issue_request(make_command('1, 1'b1, SEL_FAN, RQ_ON, 12'd1));
		issue_request(make_action(ACT_UNUSED));
		issue_request(make_action(ACT_POLL));
		release_requests();
	endtask

	task automatic test_deadlines();
		wait_until_idle();
		write_register(CFG_TPS, 12'd1);
		write_register(CFG_MAX, 12'd4095);
		issue_request(make_command(64'd2, 1'b1, SEL_FAN, RQ_ON, 12'd2));
		issue_request(make_action(ACT_TICK));
		issue_request(make_action(ACT_POLL));
		issue_request(make_action(ACT_TICK));
		issue_request(make_action(ACT_POLL));
		issue_request(make_command(64'd3, 1'b1, SEL_LIGHT, RQ_OFF, 12'd0));
		release_requests();
		// zero rate puts the deadline at the current tick
		wait_until_idle();
		write_register(CFG_TPS, 12'd0);
		issue_request(make_command(64'd4, 1'b1, SEL_FAN, RQ_ON, 12'd7));
		issue_request(make_action(ACT_POLL));
		release_requests();
	endtask

	task automatic test_backpressure();
		int n;
		wait_until_idle();
		write_register(CFG_TPS, 12'd1);
		write_register(CFG_MAX, 12'd6);
		quick_source = 1'b1;
		fork
			begin
				hold_results <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results <= 1'b0;
			end
			begin
				for (n = 0; n < 40; n++)
					issue_request(random_request(1'b1));
				release_requests();
			end
		join
		quick_source = 1'b0;
	endtask

	task automatic test_random_phases();
		logic [CFG_W-1:0] tps_plan [6];
		logic [CFG_W-1:0] max_plan [6];
		tps_plan = '{12'd1, 12'd2, 12'd1000, 12'd0, 12'hC03, 12'd1};
		max_plan = '{12'd6, 12'd4095, 12'd1, 12'd0, 12'd10, 12'd3};
		for (int p = 0; p < 6; p++) begin
			wait_until_idle();
			write_register(CFG_TPS, tps_plan[p]);
			write_register(CFG_MAX, max_plan[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 60 == 0) begin
					quick_source = ($urandom_range(0, 3) == 0);
					quick_sink <= ($urandom_range(0, 3) == 0);
				end
				issue_request(random_request(1'b0));
			end
			release_requests();
		end
		quick_source = 1'b0;
		quick_sink <= 1'b0;
	endtask

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (res_ch.valid && res_ch.ready) begin
					check_result(res_ch.data);
					stall_left = quick_sink ? 0 : $urandom_range(0, 19);
				end
				if (stall_left > 0) begin
					stall_left = stall_left - 1;
					res_ch.ready <= 1'b0;
				end else begin
					res_ch.ready <= !hold_results;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		cmd_ch.valid <= 1'b0;
		cmd_ch.data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_TPS;
		cfg_wdata <= '0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int k = 2; k < POOL_SIZE; k++)
			key_pool[k] = {$urandom, $urandom};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values_and_validation();
		test_deadlines();
		test_backpressure();
		test_random_phases();

		wait_until_idle();
		if (error_count == 0 && pending_outcomes.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* files.f */
rtl/core/iacu_pkg.sv
rtl/core/iacu_if.sv
rtl/core/iacu_cache.sv
rtl/core/idempotent_actuator_command_unit.sv
bench/tb_idempotent_actuator_command_unit.sv
